// ----- hdl/sro_pkg.sv -----
`timescale 1ns / 1ps
package sro_pkg;

  localparam int WINDOW      = 32;
  localparam int HANDLE_BITS = 16;

  localparam int ID_W     = 16;
  localparam int HNDL_W   = 16;
  localparam int SLOT_W   = $clog2(WINDOW);
  // stored handle keeps only the low HANDLE_BITS bits of the port field
  localparam int STORE_W  = (HANDLE_BITS < HNDL_W) ? HANDLE_BITS : HNDL_W;

  typedef logic [ID_W-1:0]    id_t;
  typedef logic [HNDL_W-1:0]  handle_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [STORE_W-1:0] store_t;

  typedef enum logic [1:0] {
    CLS_DROP,
    CLS_STORE,
    CLS_RELEASE
  } sro_class_t;

  // datapath to controller
  typedef struct packed {
    logic       in_valid;
    logic       out_free;
    sro_class_t cls;
    logic       nxt_valid;
  } sro_status_t;

  // controller to datapath
  typedef struct packed {
    logic take_in;
    logic drain;
    logic last;
  } sro_cmd_t;

  // slot of the id that follows; a wrap of the id space restarts at slot zero
  function automatic slot_t sro_slot_inc(slot_t slot, id_t id_next);
    slot_t res;
    if (id_next == '0) begin
      res = '0;
    end else if (slot == SLOT_W'(WINDOW - 1)) begin
      res = '0;
    end else begin
      res = slot + slot_t'(1);
    end
    return res;
  endfunction

endpackage

// ----- hdl/sro_chan_if.sv -----
`timescale 1ns / 1ps
interface sro_in_if;
  logic             valid;
  logic             ready;
  sro_pkg::id_t     seq_id;
  sro_pkg::handle_t handle;

  modport source (output valid, output seq_id, output handle, input ready);
  modport sink   (input valid, input seq_id, input handle, output ready);
endinterface

interface sro_out_if;
  logic             valid;
  logic             ready;
  sro_pkg::handle_t out_handle;
  sro_pkg::id_t     out_seq_id;
  logic             status;
  logic             last;

  modport source (output valid, output out_handle, output out_seq_id, output status,
                  output last, input ready);
  modport sink   (input valid, input out_handle, input out_seq_id, input status,
                  input last, output ready);
endinterface

// ----- hdl/sro_datapath.sv -----
`timescale 1ns / 1ps
module sro_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  sro_pkg::id_t         in_seq_id,
  input  sro_pkg::handle_t     in_handle,
  input  logic                 out_ready,
  output logic                 out_valid,
  output sro_pkg::handle_t     out_handle,
  output sro_pkg::id_t         out_seq_id,
  output logic                 out_status,
  output logic                 out_last,
  input  sro_pkg::sro_cmd_t    cmd,
  output sro_pkg::sro_status_t sts
);
  import sro_pkg::*;

  id_t                 exp_id_r;
  slot_t               exp_slot_r;
  logic [WINDOW-1:0]   valid_r;
  store_t              handle_r [WINDOW];

  logic                out_valid_r;
  handle_t             out_handle_r;
  id_t                 out_seq_id_r;
  logic                out_status_r;
  logic                out_last_r;

  id_t                 id_diff;
  sro_class_t          cls;
  logic [SLOT_W:0]     slot_sum;
  slot_t               in_slot;
  id_t                 exp_id_inc;
  slot_t               nxt_slot;
  store_t              in_store;
  logic                out_free;
  logic                do_release;
  logic                do_drop;
  logic                do_store;
  logic                advance;
  logic                load;

  assign id_diff    = in_seq_id - exp_id_r;
  assign exp_id_inc = exp_id_r + id_t'(1);
  assign nxt_slot   = sro_slot_inc(exp_slot_r, exp_id_inc);
  assign in_store   = in_handle[STORE_W-1:0];
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    if (id_diff == '0) begin
      cls = CLS_RELEASE;
    end else if (id_diff < ID_W'(WINDOW)) begin
      cls = CLS_STORE;
    end else begin
      cls = CLS_DROP;
    end
  end

  // slot of an id ahead in the window, from the expected slot plus distance
  always_comb begin
    slot_sum = {1'b0, exp_slot_r} + id_diff[SLOT_W:0];
    if (in_seq_id < exp_id_r) begin
      in_slot = in_seq_id[SLOT_W-1:0];
    end else if (slot_sum >= (SLOT_W + 1)'(WINDOW)) begin
      in_slot = SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW));
    end else begin
      in_slot = slot_sum[SLOT_W-1:0];
    end
  end

  assign do_release = cmd.take_in && (cls == CLS_RELEASE);
  assign do_drop    = cmd.take_in && (cls == CLS_DROP);
  assign do_store   = cmd.take_in && (cls == CLS_STORE);
  assign advance    = do_release || cmd.drain;
  assign load       = advance || do_drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r    <= '0;
      exp_slot_r  <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        exp_id_r   <= exp_id_inc;
        exp_slot_r <= nxt_slot;
      end
      if (do_store) begin
        valid_r[in_slot] <= 1'b1;
      end else if (cmd.drain) begin
        valid_r[exp_slot_r] <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_store) begin
      handle_r[in_slot] <= in_store;
    end
    if (cmd.drain) begin
      out_handle_r <= HNDL_W'(handle_r[exp_slot_r]);
      out_seq_id_r <= exp_id_r;
      out_status_r <= 1'b0;
      out_last_r   <= cmd.last;
    end else if (do_release) begin
      out_handle_r <= HNDL_W'(in_store);
      out_seq_id_r <= in_seq_id;
      out_status_r <= 1'b0;
      out_last_r   <= cmd.last;
    end else if (do_drop) begin
      out_handle_r <= HNDL_W'(in_store);
      out_seq_id_r <= in_seq_id;
      out_status_r <= 1'b1;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_handle = out_handle_r;
  assign out_seq_id = out_seq_id_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  assign sts.in_valid  = in_valid;
  assign sts.out_free  = out_free;
  assign sts.cls       = cls;
  assign sts.nxt_valid = valid_r[nxt_slot];

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free)
    else $error("result register loaded while holding an untaken word");

  a_drain_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain |-> valid_r[exp_slot_r])
    else $error("drain step on an empty slot");

  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> out_last_r)
    else $error("dropped word not marked last");

  a_exp_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (exp_id_r != $past(exp_id_r))) |->
      (exp_id_r == $past(exp_id_inc)))
    else $error("expected id moved by other than one");
`endif

endmodule

// ----- hdl/sro_ctrl.sv -----
`timescale 1ns / 1ps
module sro_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sro_pkg::sro_status_t sts,
  output logic                 in_ready,
  output sro_pkg::sro_cmd_t    cmd
);
  import sro_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  state_t state_r;
  slot_t  cnt_r;

  assign in_ready = (state_r == ST_IDLE) && sts.out_free;

  always_comb begin
    cmd.take_in = 1'b0;
    cmd.drain   = 1'b0;
    cmd.last    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.take_in = sts.in_valid && in_ready;
        cmd.last    = !sts.nxt_valid;
      end
      ST_DRAIN: begin
        cmd.drain = sts.out_free;
        // at most one window less one stored words follow the arrival
        cmd.last  = !sts.nxt_valid || (cnt_r == SLOT_W'(WINDOW - 1));
      end
      default: begin
        cmd.take_in = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.take_in && (sts.cls == CLS_RELEASE) && !cmd.last) begin
            state_r <= ST_DRAIN;
            cnt_r   <= slot_t'(1);
          end
        end
        ST_DRAIN: begin
          if (cmd.drain) begin
            if (cmd.last) begin
              state_r <= ST_IDLE;
            end else begin
              cnt_r <= cnt_r + slot_t'(1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/sequence_reorder_buffer_core.sv -----
`timescale 1ns / 1ps
// a released or dropped word is registered and shown in the cycle after its arrival is accepted
// throughput (output taken): one arrival per cycle while nothing drains; an in-order
//   arrival that finds k stored successors gives k + 1 words at one per cycle, set by
//   the single slot read port; the next arrival waits until the last drained word is loaded
// reset (synchronous, active low): expected id 0, all slot valid bits cleared at once
module sequence_reorder_buffer_core (
  input logic      clk,
  input logic      rst_n,
  sro_in_if.sink   in_ch,
  sro_out_if.source out_ch
);
  import sro_pkg::*;

  sro_cmd_t    cmd;
  sro_status_t sts;
  logic        in_ready;

  assign in_ch.ready = in_ready;

  sro_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  sro_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_seq_id  (in_ch.seq_id),
    .in_handle  (in_ch.handle),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_handle (out_ch.out_handle),
    .out_seq_id (out_ch.out_seq_id),
    .out_status (out_ch.status),
    .out_last   (out_ch.last),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ----- dv/sequence_reorder_buffer_core_test.sv -----
`timescale 1ns / 1ps
module sequence_reorder_buffer_core_test;
  import sro_pkg::*;

  localparam logic STATUS_RELEASED = 1'b0;
  localparam logic STATUS_DROPPED  = 1'b1;
  localparam int   RANDOM_WORDS    = 330;
  localparam int   DRAIN_LIMIT     = 20000;

  typedef struct packed {
    handle_t handle;
    id_t     seq_id;
    logic    status;
    logic    last;
  } reorder_word_t;

  logic clk = 1'b0;
  logic rst_n;

  sro_in_if  in_ch ();
  sro_out_if out_ch ();

  sequence_reorder_buffer_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // shadow of the buffer state
  id_t    next_id;
  logic   slot_full [WINDOW];
  store_t slot_tag  [WINDOW];

  reorder_word_t release_queue[$];

  int error_count      = 0;
  int words_sent       = 0;
  int burst_left       = 0;
  bit sender_steady    = 1'b0;
  bit receiver_steady  = 1'b0;

  function automatic void clear_shadow();
    next_id = '0;
    foreach (slot_full[k]) begin
      slot_full[k] = 1'b0;
      slot_tag[k]  = '0;
    end
    release_queue.delete();
  endfunction

  // words that one accepted arrival hands onward, in order
  function automatic void predict_arrival(id_t id, handle_t h);
    id_t           id_diff;
    slot_t         s;
    store_t        tag;
    reorder_word_t w;
    tag      = store_t'(h);
    id_diff  = id - next_id;
    w.handle = handle_t'(tag);
    w.seq_id = id;
    w.status = STATUS_DROPPED;
    w.last   = 1'b1;
    if (id_diff >= id_t'(WINDOW)) begin
      release_queue.push_back(w);
    end else if (id_diff != '0) begin
      s            = slot_t'(id % WINDOW);
      slot_full[s] = 1'b1;
      slot_tag[s]  = tag;
    end else begin
      w.status = STATUS_RELEASED;
      w.last   = 1'b0;
      next_id  = next_id + 1'b1;
      for (int k = 0; k < WINDOW - 1; k++) begin
        s = slot_t'(next_id % WINDOW);
        if (!slot_full[s]) break;
        release_queue.push_back(w);
        w.handle     = handle_t'(slot_tag[s]);
        w.seq_id     = next_id;
        slot_full[s] = 1'b0;
        next_id      = next_id + 1'b1;
      end
      w.last = 1'b1;
      release_queue.push_back(w);
    end
  endfunction

  task automatic send_word(id_t id, handle_t h);
    int gap;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) :
                                                   $urandom_range(1, 10);
      end
      burst_left--;
    end
    in_ch.valid  <= 1'b1;
    in_ch.seq_id <= id;
    in_ch.handle <= h;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    predict_arrival(id, h);
  endtask

  task automatic test_in_order_release();
    send_word(16'h0000, 16'h0000);
    send_word(16'h0001, 16'hFFFF);
    send_word(16'h0002, 16'h5A5A);
  endtask

  task automatic test_dropped_arrivals();
    send_word(next_id - 1'b1, 16'hFFFF);
    // first id past the window
    send_word(next_id + id_t'(WINDOW), 16'h0000);
    send_word(next_id + 16'h8000, 16'h1234);
    send_word(16'hFFFF, 16'hA5A5);
  endtask

  task automatic test_store_and_drain();
    id_t base;
    base = next_id;
    // farthest id still inside the window stays parked
    send_word(base + id_t'(WINDOW - 1), 16'h7E7E);
    send_word(base + 16'd2, 16'h0F0F);
    send_word(base + 16'd1, 16'h1111);
    // duplicate ahead overwrites the earlier handle
    send_word(base + 16'd1, 16'hEEEE);
    send_word(base + 16'd4, 16'h4444);
    // drain stops at the hole left by base + 3
    send_word(base, 16'hC3C3);
    send_word(base + 16'd3, 16'h3333);
  endtask

  task automatic test_distance_wrap();
    id_t wrap_ids[$];
    // short in-order run with no idling on either side
    sender_steady   = 1'b1;
    receiver_steady = 1'b1;
    repeat (16) begin
      send_word(next_id, handle_t'($urandom));
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    // ids below the expected one wrap to a large distance
    wrap_ids = '{16'h0002, 16'hFFFD, 16'h0000, 16'hFFFF, 16'hFFFA,
                 16'h0001, 16'hFFFB, 16'hFFF9, 16'hFFFC, 16'hFFFE};
    foreach (wrap_ids[k]) begin
      send_word(wrap_ids[k], handle_t'($urandom));
    end
    send_word(16'hFFF8, handle_t'($urandom));
    send_word(16'hFFF0, handle_t'($urandom));
    send_word(16'h8003, handle_t'($urandom));
  endtask

  task automatic test_random_traffic();
    int            start;
    int            kind;
    int            n;
    int            j;
    int            r;
    id_t           base;
    id_t           tmp;
    id_t           block_ids[$];
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_word(id_t'($urandom), handle_t'($urandom));
      end else if (kind == 1) begin
        send_word(next_id - id_t'($urandom_range(1, 600)), handle_t'($urandom));
      end else if (kind == 2) begin
        send_word(next_id + id_t'(WINDOW + $urandom_range(0, 8)), handle_t'($urandom));
      end else begin
        // a run of consecutive ids in shuffled order
        base = next_id;
        n    = ($urandom_range(0, 7) == 0) ? WINDOW : $urandom_range(1, 8);
        block_ids.delete();
        for (int k = 1; k < n; k++) begin
          block_ids.push_back(base + id_t'(k));
        end
        for (int k = n - 2; k > 0; k--) begin
          j            = $urandom_range(0, k);
          tmp          = block_ids[k];
          block_ids[k] = block_ids[j];
          block_ids[j] = tmp;
        end
        // a full window keeps the expected id last so everything drains at once
        block_ids.push_back(base);
        if (n != WINDOW && $urandom_range(0, 1) == 1) begin
          j                = $urandom_range(0, n - 1);
          tmp              = block_ids[n - 1];
          block_ids[n - 1] = block_ids[j];
          block_ids[j]     = tmp;
        end
        // broken run: one id lost, another repeated
        if ($urandom_range(0, 4) == 0) begin
          j            = $urandom_range(0, n - 1);
          r            = $urandom_range(0, n - 1);
          block_ids[j] = block_ids[r];
        end
        foreach (block_ids[k]) begin
          send_word(block_ids[k], handle_t'($urandom));
        end
      end
    end
  endtask

  // result side: check each accepted word, then pick the next ready value
  initial begin
    int            mode;
    int            mode_left;
    int            phase;
    reorder_word_t want;
    mode         = 0;
    mode_left    = 0;
    phase        = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (release_queue.size() == 0) begin
          $error("word with no expectation: out_seq_id %h out_handle %h",
                 out_ch.out_seq_id, out_ch.out_handle);
          error_count++;
        end else begin
          want = release_queue.pop_front();
          if (out_ch.out_handle !== want.handle) begin
            $error("out_handle: expected %h, actual %h", want.handle, out_ch.out_handle);
            error_count++;
          end
          if (out_ch.out_seq_id !== want.seq_id) begin
            $error("out_seq_id: expected %h, actual %h", want.seq_id, out_ch.out_seq_id);
            error_count++;
          end
          if (out_ch.status !== want.status) begin
            $error("status: expected %b, actual %b", want.status, out_ch.status);
            error_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_ch.last);
            error_count++;
          end
        end
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      phase++;
      if (receiver_steady || mode == 0) begin
        out_ch.ready <= 1'b1;
      end else if (mode == 1) begin
        out_ch.ready <= ($urandom_range(0, 2) != 0);
      end else begin
        out_ch.ready <= (phase % 4 == 3);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int guard;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.seq_id <= '0;
    in_ch.handle <= '0;
    clear_shadow();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_in_order_release();
    test_dropped_arrivals();
    test_store_and_drain();
    test_distance_wrap();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    guard = 0;
    while (release_queue.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (release_queue.size() != 0) begin
      $error("%0d expected words never arrived", release_queue.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
